// ===== design/cun_pkg.sv =====
// shared types and constants for the complex unit normalizer
// no dependencies; used by every module of the block
package cun_pkg;

  // sample format: SampleBits bits, one integer bit, the rest fraction
  localparam int SampleBits = 16;
  // width of the quotient, wide enough to hold plus one at the sample format
  localparam int QBits      = SampleBits + 1;
  // squares and the right-hand side of the root compare
  localparam int SqBits     = 2 * SampleBits;
  localparam int RhsBits    = 4 * SampleBits;
  // running sums of the bit-serial compare, signed
  localparam int AccBits    = 4 * SampleBits + 3;
  // pipeline depth from an accepted beat to its result strobe
  localparam int Latency    = SampleBits + 3;

  localparam logic [QBits-1:0] FullScale = QBits'(1) << (SampleBits - 1);

  typedef struct packed {
    logic signed [SampleBits-1:0] re_in;
    logic signed [SampleBits-1:0] im_in;
  } cun_in_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] re_out;
    logic signed [SampleBits-1:0] im_out;
  } cun_out_t;

  // one part of the sample as it moves down the quotient stages
  typedef struct packed {
    logic                      neg;
    logic [QBits-1:0]          q;
    logic signed [AccBits-1:0] s;    // (2q-1)^2 * norm
    logic signed [AccBits-1:0] p;    // (2q-1) * norm
    logic signed [AccBits-1:0] rhs;  // 4 * mag^2 * FullScale^2
  } cun_lane_t;

  typedef struct packed {
    logic             valid;
    logic [SqBits-1:0] norm;
    cun_lane_t        re;
    cun_lane_t        im;
  } cun_stage_t;

endpackage

// ===== design/cun_prep.sv =====
// front stages: magnitudes, squares and the seed of the quotient search
// depends on cun_pkg
module cun_prep (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  cun_pkg::cun_in_t in_i,
  output cun_pkg::cun_stage_t stage_o
);
  import cun_pkg::*;

  logic                  v1_q, v2_q;
  logic                  neg_re_q, neg_im_q, neg_re2_q, neg_im2_q;
  logic [SampleBits-1:0] abs_re_q, abs_im_q;
  logic [SqBits-1:0]     sq_re_q, sq_im_q, norm_q;
  logic [SqBits-1:0]     sq_re_d, sq_im_d;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // stage one: absolute values, the most negative code maps to plus one
  always_ff @(posedge clk_i) begin
    neg_re_q <= in_i.re_in[SampleBits-1];
    neg_im_q <= in_i.im_in[SampleBits-1];
    abs_re_q <= in_i.re_in[SampleBits-1] ? SampleBits'(-in_i.re_in) : in_i.re_in;
    abs_im_q <= in_i.im_in[SampleBits-1] ? SampleBits'(-in_i.im_in) : in_i.im_in;
  end

  // stage two: squares and squared norm
  always_comb begin
    sq_re_d = SqBits'(abs_re_q) * SqBits'(abs_re_q);
    sq_im_d = SqBits'(abs_im_q) * SqBits'(abs_im_q);
  end

  always_ff @(posedge clk_i) begin
    neg_re2_q <= neg_re_q;
    neg_im2_q <= neg_im_q;
    sq_re_q   <= sq_re_d;
    sq_im_q   <= sq_im_d;
    norm_q    <= sq_re_d + sq_im_d;
  end

  // seed with q = 0, so 2q-1 = -1
  always_comb begin
    stage_o.valid  = v2_q;
    stage_o.norm   = norm_q;
    stage_o.re.neg = neg_re2_q;
    stage_o.re.q   = '0;
    stage_o.re.s   = AccBits'(norm_q);
    stage_o.re.p   = -AccBits'(norm_q);
    stage_o.re.rhs = AccBits'({sq_re_q, {SqBits{1'b0}}});
    stage_o.im.neg = neg_im2_q;
    stage_o.im.q   = '0;
    stage_o.im.s   = AccBits'(norm_q);
    stage_o.im.p   = -AccBits'(norm_q);
    stage_o.im.rhs = AccBits'({sq_im_q, {SqBits{1'b0}}});
  end

endmodule

// ===== design/cun_step.sv =====
// one quotient bit for both parts: try setting bit BIT_IDX, keep it if it fits
// depends on cun_pkg
module cun_step #(
  parameter int BIT_IDX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cun_pkg::cun_stage_t stage_i,
  output cun_pkg::cun_stage_t stage_o
);
  import cun_pkg::*;

  localparam logic [QBits-1:0] Bit = QBits'(1) << BIT_IDX;

  cun_stage_t stage_d, stage_q;
  logic valid_q;
  logic signed [AccBits-1:0] norm_p, norm_s;

  // norm terms for d -> d + 2*bit
  assign norm_p = AccBits'(stage_i.norm) <<< (BIT_IDX + 1);
  assign norm_s = AccBits'(stage_i.norm) <<< (2 * BIT_IDX + 2);

  function automatic cun_lane_t step_lane(cun_lane_t l, logic signed [AccBits-1:0] np,
                                          logic signed [AccBits-1:0] ns);
    cun_lane_t r;
    logic [QBits-1:0] t;
    logic signed [AccBits-1:0] s_try;
    r     = l;
    t     = l.q | Bit;
    s_try = l.s + (l.p <<< (BIT_IDX + 2)) + ns;
    if (t <= FullScale && s_try <= l.rhs) begin
      r.q = t;
      r.s = s_try;
      r.p = l.p + np;
    end
    return r;
  endfunction

  // trial of this bit on both parts
  always_comb begin
    stage_d       = stage_i;
    stage_d.re    = step_lane(stage_i.re, norm_p, norm_s);
    stage_d.im    = step_lane(stage_i.im, norm_p, norm_s);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  always_comb begin
    stage_o       = stage_q;
    stage_o.valid = valid_q;
  end

endmodule

// ===== design/complex_unit_normalize.sv =====
// top level of the complex unit normalizer: front stages, quotient chain, output
// depends on cun_pkg, cun_prep and cun_step
//
// Usage
//   A sample is taken at every rising edge with start_i high and busy_o low.
//   busy_o is always low: the pipeline takes one sample per cycle with no gaps.
//   Each sample yields exactly one result on out_o, marked by valid_o for one
//   cycle, in the order the samples were taken.
//   The pipeline has two front stages for magnitudes and squares, one stage
//   per quotient bit and one output stage.
//   Throughput is one sample per cycle; each quotient stage settles one bit
//   of both parts with shift-and-add updates, so no divider or root unit.
//   Result: each part divided by the magnitude, rounded to nearest with ties
//   away from zero, plus one saturated to the largest positive code; a zero
//   sample gives zero parts.
//   Reset clears every valid bit, so no result appears until samples arrive.
//   The receiver cannot stall; results are shown once and never held.
module complex_unit_normalize (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  cun_pkg::cun_in_t  in_i,
  output logic              valid_o,
  output cun_pkg::cun_out_t out_o
);
  import cun_pkg::*;

  cun_stage_t chain [SampleBits+1];
  cun_out_t   out_d, out_q;
  logic       valid_q;

  assign busy_o = 1'b0;

  // magnitudes and squares
  cun_prep u_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(start_i),
    .in_i   (in_i),
    .stage_o(chain[0])
  );

  // one stage per quotient bit, most significant first
  for (genvar g = 0; g < SampleBits; g++) begin : g_step
    cun_step #(
      .BIT_IDX(SampleBits - 1 - g)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .stage_i(chain[g]),
      .stage_o(chain[g+1])
    );
  end

  function automatic logic [SampleBits-1:0] part_out(cun_lane_t l, logic zero);
    logic [SampleBits-1:0] r;
    if (zero) begin
      r = '0;
    end else if (l.neg) begin
      r = SampleBits'(-l.q);
    end else if (l.q >= FullScale) begin
      r = SampleBits'(FullScale - QBits'(1));
    end else begin
      r = SampleBits'(l.q);
    end
    return r;
  endfunction

  // sign, saturation and zero handling
  always_comb begin
    out_d.re_out = part_out(chain[SampleBits].re, chain[SampleBits].norm == '0);
    out_d.im_out = part_out(chain[SampleBits].im, chain[SampleBits].norm == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= chain[SampleBits].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign valid_o = valid_q;
  assign out_o   = out_q;

  // result strobe follows the accepted beat by the pipeline depth
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##Latency (valid_o == $past(start_i && !busy_o, Latency)))
    else $error("result strobe does not match accepted beat");

  // zero sample gives zero parts
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && in_i.re_in == '0 && in_i.im_in == '0) |-> ##Latency
    (valid_o && out_o.re_out == '0 && out_o.im_out == '0))
    else $error("zero sample gave nonzero result");

  // a positive real part never turns negative
  a_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !in_i.re_in[SampleBits-1]) |-> ##Latency
    (!out_o.re_out[SampleBits-1]))
    else $error("real part changed sign");

endmodule
